FILE: src/circle_circle_intersection_macros.svh
// Assertion macros shared by the circle intersection RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef CIRCLE_CIRCLE_INTERSECTION_MACROS_SVH
`define CIRCLE_CIRCLE_INTERSECTION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CCI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CCI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/cci_pkg.sv
// Shared types and widths for the circle intersection block.
// No dependencies; imported by every module of the block.
package cci_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned RadW     = 31;
  localparam int unsigned StampW   = 32;
  localparam int unsigned DiffW    = 33;
  localparam int unsigned SqW      = 66;
  localparam int unsigned RootW    = 33;
  localparam int unsigned MulW     = 36;
  localparam int unsigned AccW     = 72;
  localparam int unsigned DenW     = 34;
  localparam int unsigned OffW     = 36;
  localparam int unsigned InDataW  = 256;
  localparam int unsigned OutDataW = 192;
  localparam int unsigned StatusW  = 3;

  typedef enum logic [StatusW-1:0] {
    ST_CROSS      = 3'd0,
    ST_OUTER      = 3'd1,
    ST_INNER      = 3'd2,
    ST_COINCIDENT = 3'd3,
    ST_NONE       = 3'd4
  } status_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic signed [CoordW-1:0] x2;
    logic signed [CoordW-1:0] y2;
    logic signed [DiffW-1:0]  dx;
    logic signed [DiffW-1:0]  dy;
    logic [RadW-1:0]          r1;
    logic [RadW-1:0]          r2;
    logic [RadW:0]            rsum;
    logic [RadW-1:0]          rdif;
    logic                     r2_gt_r1;
    logic                     coincident;
    logic [StampW-1:0]        st1;
    logic [StampW-1:0]        st2;
  } job_t;

  typedef struct packed {
    logic signed [CoordW-1:0] p3x;
    logic signed [CoordW-1:0] p3y;
    logic signed [CoordW-1:0] p4x;
    logic signed [CoordW-1:0] p4y;
    status_e                  status;
    logic                     two;
    logic [RadW-1:0]          r1;
    logic [RadW-1:0]          r2;
    logic [StampW-1:0]        st1;
    logic [StampW-1:0]        st2;
  } rec_t;

endpackage

FILE: src/circle_circle_intersection.sv
// Top level of the circle intersection block: config register, front, queue,
// back and output stage. Depends on cci_pkg, cci_front, cci_queue, cci_back and cci_out.
//
//   Channel   Direction  Handshake                   Payload
//   s_axis    in         s_axis_tvalid/tready        tdata: two circles
//   m_axis    out        m_axis_tvalid/tready        tdata: point, tuser: status, tlast
//   cfg       in         cfg_valid_i/cfg_ready_o     cfg_data_i: virtual_enable
//
// Crossing circles take longest, separate or nested ones less, and coincident
// centres skip the arithmetic; the one-bit-per-cycle divider and square root set this.
// Reset clears the sequencer, the queue and the output stage; virtual_enable
// resets to 1. The front keeps accepting until the queue fills, and a finished
// record waits in the output stage while the back part starts the next request.
module circle_circle_intersection
  import cci_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // c1x, c1y, radius1, stamp1, c2x, c2y, radius2, stamp2, two zero bits
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // point_x, point_y, radius1_out, radius2_out, stamp1_out, stamp2_out, two zero bits
  output logic [OutDataW-1:0] m_axis_tdata,
  // status
  output logic [StatusW-1:0]  m_axis_tuser,
  output logic                m_axis_tlast,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);

  logic ve_q;
  logic push, full, pop, empty, rec_valid, rec_ready;
  job_t job_in, job_out;
  rec_t rec;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b1;
    end else if (cfg_valid_i) begin
      ve_q <= cfg_data_i;
    end
  end

  cci_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .full_i        (full),
    .push_o        (push),
    .job_o         (job_in)
  );

  cci_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (job_out)
  );

  cci_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ve_i        (ve_q),
    .q_empty_i   (empty),
    .pop_o       (pop),
    .job_i       (job_out),
    .rec_valid_o (rec_valid),
    .rec_ready_i (rec_ready),
    .rec_o       (rec)
  );

  cci_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_valid_i   (rec_valid),
    .rec_ready_o   (rec_ready),
    .rec_i         (rec),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: src/cci_front.sv
// Input side: unpacks a request, forms centre differences and radius terms.
// Depends on cci_pkg; feeds cci_queue.
module cci_front
  import cci_pkg::*;
(
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // c1x, c1y, radius1, stamp1, c2x, c2y, radius2, stamp2, two zero bits
  input  logic [InDataW-1:0] s_axis_tdata,
  input  logic               full_i,
  output logic               push_o,
  output job_t               job_o
);

  logic [RadW-1:0] r1, r2;

  assign r1 = s_axis_tdata[94:64];
  assign r2 = s_axis_tdata[221:191];

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

  always_comb begin
    job_o.x1         = s_axis_tdata[31:0];
    job_o.y1         = s_axis_tdata[63:32];
    job_o.st1        = s_axis_tdata[126:95];
    job_o.x2         = s_axis_tdata[158:127];
    job_o.y2         = s_axis_tdata[190:159];
    job_o.st2        = s_axis_tdata[253:222];
    job_o.r1         = r1;
    job_o.r2         = r2;
    job_o.dx         = {job_o.x2[CoordW-1], job_o.x2} - {job_o.x1[CoordW-1], job_o.x1};
    job_o.dy         = {job_o.y2[CoordW-1], job_o.y2} - {job_o.y1[CoordW-1], job_o.y1};
    job_o.rsum       = {1'b0, r1} + {1'b0, r2};
    job_o.r2_gt_r1   = r2 > r1;
    job_o.rdif       = job_o.r2_gt_r1 ? (r2 - r1) : (r1 - r2);
    job_o.coincident = (job_o.dx == '0) && (job_o.dy == '0);
  end

endmodule

FILE: src/cci_queue.sv
// Short queue of prepared requests between the front and the back part.
// Depends on cci_pkg.
module cci_queue
  import cci_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t job_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign job_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: src/cci_div.sv
// Radix-2 divider: signed numerator by unsigned divisor, truncated toward
// zero, quotient clamped to +-2^34. Depends on cci_pkg.
module cci_div
  import cci_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [AccW-1:0] num_i,
  input  logic [DenW-1:0]        den_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic signed [OffW-1:0] off_o
);

  localparam int unsigned QW   = OffW;
  localparam int unsigned CntW = $clog2(QW + 1);
  localparam logic [QW-1:0] Lim = QW'(64'h4_0000_0000);

  logic                busy_q, done_q;
  logic [CntW-1:0]     cnt_q;
  logic [DenW-1:0]     den_q, rem_q;
  logic [QW-1:0]       low_q, quo_q;
  logic                neg_q, sat_q;
  logic [AccW-1:0]     mag;
  logic [AccW-QW-1:0]  hi;
  logic [DenW:0]       trial;
  logic                fits;
  logic [QW-1:0]       qc;

  assign mag   = num_i[AccW-1] ? AccW'(-num_i) : AccW'(num_i);
  assign hi    = mag[AccW-1:QW];
  assign trial = {rem_q, low_q[QW-1]};
  assign fits  = trial >= {1'b0, den_q};

  assign qc     = (sat_q || (quo_q > Lim)) ? Lim : quo_q;
  assign off_o  = neg_q ? -$signed(qc) : $signed(qc);
  assign busy_o = busy_q;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      neg_q <= num_i[AccW-1];
      // A high part at or above the divisor means the quotient needs more bits.
      sat_q <= hi >= (AccW-QW)'(den_i);
      rem_q <= (hi >= (AccW-QW)'(den_i)) ? '0 : DenW'(hi);
      low_q <= mag[QW-1:0];
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? DenW'(trial - {1'b0, den_q}) : DenW'(trial);
      low_q <= {low_q[QW-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], fits};
    end
  end

endmodule

FILE: src/cci_sqrt.sv
// Digit-by-digit integer square root, rounded down, one root bit per cycle.
// Depends on cci_pkg.
module cci_sqrt
  import cci_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SqW-1:0]   rad_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);

  localparam int unsigned RemW = RootW + 3;
  localparam int unsigned CntW = $clog2(RootW + 1);

  logic              busy_q, done_q;
  logic [CntW-1:0]   cnt_q;
  logic [SqW-1:0]    rad_q;
  logic [RemW-1:0]   rem_q;
  logic [RootW-1:0]  root_q;
  logic [RemW:0]     cur, trial;
  logic              fits;

  assign cur    = {rem_q[RemW-2:0], rad_q[SqW-1:SqW-2]};
  assign trial  = (RemW+1)'({root_q, 2'b01});
  assign fits   = cur >= trial;
  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(RootW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[SqW-3:0], 2'b00};
      rem_q  <= fits ? RemW'(cur - trial) : RemW'(cur);
      root_q <= {root_q[RootW-2:0], fits};
    end
  end

endmodule

FILE: src/cci_back.sv
// Back part: sequencer with one shared multiplier, a divider and a square
// root unit. Depends on cci_pkg, cci_div, cci_sqrt and the assertion macros.
`include "circle_circle_intersection_macros.svh"

module cci_back
  import cci_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic ve_i,
  input  logic q_empty_i,
  output logic pop_o,
  input  job_t job_i,
  output logic rec_valid_o,
  input  logic rec_ready_i,
  output rec_t rec_o
);

  typedef enum logic [27:0] {
    S_IDLE  = 28'h0000001, S_SQDX  = 28'h0000002, S_SQDY  = 28'h0000004,
    S_SQRS  = 28'h0000008, S_SQRD  = 28'h0000010, S_SQR1  = 28'h0000020,
    S_DROOT = 28'h0000040, S_VMX   = 28'h0000080, S_VAX   = 28'h0000100,
    S_VWX   = 28'h0000200, S_VWY   = 28'h0000400, S_AR2   = 28'h0000800,
    S_ANUM  = 28'h0001000, S_AWAIT = 28'h0002000, S_HSQ   = 28'h0004000,
    S_HSUB  = 28'h0008000, S_HWAIT = 28'h0010000, S_PADX  = 28'h0020000,
    S_PHDY  = 28'h0040000, S_PSX   = 28'h0080000, S_DX3   = 28'h0100000,
    S_DX4   = 28'h0200000, S_PADY  = 28'h0400000, S_PHDX  = 28'h0800000,
    S_PSY   = 28'h1000000, S_DY3   = 28'h2000000, S_DY4   = 28'h4000000,
    S_EMIT  = 28'h8000000
  } state_e;

  state_e state_q, state_d;

  job_t                     job_q;
  logic [SqW-1:0]           s_q, s_d;
  logic                     outer_q, outer_d, inner_q, inner_d;
  logic [RootW-1:0]         d_q, d_d;
  logic [DenW-1:0]          k_q, k_d;
  logic [2*RadW-1:0]        r1sq_q, r1sq_d;
  logic signed [OffW-1:0]   a_q, a_d;
  logic [RadW:0]            h_q, h_d;
  logic [2*MulW-1:0]        prod_q;
  logic signed [AccW-1:0]   acc_q, acc_d, acc2_q, acc2_d;
  logic signed [CoordW-1:0] p3x_q, p3x_d, p3y_q, p3y_d, p4x_q, p4x_d, p4y_q, p4y_d;
  status_e                  stat_q, stat_d;
  logic                     two_q, two_d;

  logic              mul_en;
  logic [MulW-1:0]   mul_a, mul_b;
  logic [DiffW-1:0]  dxm, dym;
  logic [MulW-1:0]   am;
  logic              dxneg, dyneg, aneg, vneg;
  logic signed [CoordW-1:0] vbx, vby;
  logic signed [RadW+3:0]   kfull;

  logic                   div_start, div_busy, div_done, den_d2;
  logic [DenW-1:0]        div_den;
  logic signed [OffW-1:0] div_off;
  logic                   sqrt_start, sqrt_busy, sqrt_done;
  logic [SqW-1:0]         sqrt_rad;
  logic [RootW-1:0]       sqrt_root;

  function automatic logic signed [AccW-1:0] sgn(input logic [2*MulW-1:0] m,
                                                 input logic neg);
    sgn = neg ? -$signed(AccW'(m)) : $signed(AccW'(m));
  endfunction

  function automatic logic signed [CoordW-1:0] place(input logic signed [CoordW-1:0] b,
                                                     input logic signed [OffW-1:0] o);
    logic signed [OffW:0] sum;
    sum = (OffW+1)'(b) + (OffW+1)'(o);
    if (sum > (OffW+1)'(32'sh7FFF_FFFF)) begin
      place = 32'sh7FFF_FFFF;
    end else if (sum < -(OffW+1)'(33'sh0_8000_0000)) begin
      place = 32'sh8000_0000;
    end else begin
      place = sum[CoordW-1:0];
    end
  endfunction

  assign dxneg = job_q.dx[DiffW-1];
  assign dyneg = job_q.dy[DiffW-1];
  assign aneg  = a_q[OffW-1];
  assign dxm   = dxneg ? DiffW'(-job_q.dx) : DiffW'(job_q.dx);
  assign dym   = dyneg ? DiffW'(-job_q.dy) : DiffW'(job_q.dy);
  assign am    = aneg ? MulW'(-a_q) : MulW'(a_q);
  // Virtual points measured from the second centre when it is outer or the larger.
  assign vneg  = outer_q || job_q.r2_gt_r1;
  assign vbx   = vneg ? job_q.x2 : job_q.x1;
  assign vby   = vneg ? job_q.y2 : job_q.y1;
  assign kfull = outer_q ? ((RadW+4)'(sqrt_root) - (RadW+4)'(job_q.r1) + (RadW+4)'(job_q.r2))
                         : ((RadW+4)'(sqrt_root) + (RadW+4)'(job_q.r1) + (RadW+4)'(job_q.r2));

  assign div_den  = den_d2 ? {d_q, 1'b0} : DenW'(d_q);
  assign sqrt_rad = (state_q == S_SQR1) ? s_q : SqW'(acc_d);

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      S_SQDX:  begin mul_a = MulW'(dxm);        mul_b = MulW'(dxm);        end
      S_SQDY:  begin mul_a = MulW'(dym);        mul_b = MulW'(dym);        end
      S_SQRS:  begin mul_a = MulW'(job_q.rsum); mul_b = MulW'(job_q.rsum); end
      S_SQRD:  begin mul_a = MulW'(job_q.rdif); mul_b = MulW'(job_q.rdif); end
      S_SQR1:  begin mul_a = MulW'(job_q.r1);   mul_b = MulW'(job_q.r1);   end
      S_VMX:   begin mul_a = MulW'(dxm);        mul_b = MulW'(k_q);        end
      S_VAX:   begin mul_a = MulW'(dym);        mul_b = MulW'(k_q);        end
      S_AR2:   begin mul_a = MulW'(job_q.r2);   mul_b = MulW'(job_q.r2);   end
      S_HSQ:   begin mul_a = am;                mul_b = am;                end
      S_PADX:  begin mul_a = am;                mul_b = MulW'(dxm);        end
      S_PHDY:  begin mul_a = MulW'(h_q);        mul_b = MulW'(dym);        end
      S_PADY:  begin mul_a = am;                mul_b = MulW'(dym);        end
      S_PHDX:  begin mul_a = MulW'(h_q);        mul_b = MulW'(dxm);        end
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    s_d         = s_q;
    outer_d     = outer_q;
    inner_d     = inner_q;
    d_d         = d_q;
    k_d         = k_q;
    r1sq_d      = r1sq_q;
    a_d         = a_q;
    h_d         = h_q;
    acc_d       = acc_q;
    acc2_d      = acc2_q;
    p3x_d       = p3x_q;
    p3y_d       = p3y_q;
    p4x_d       = p4x_q;
    p4y_d       = p4y_q;
    stat_d      = stat_q;
    two_d       = two_q;
    pop_o       = 1'b0;
    rec_valid_o = 1'b0;
    div_start   = 1'b0;
    den_d2      = 1'b1;
    sqrt_start  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          if (job_i.coincident) begin
            p3x_d   = '0;
            p3y_d   = '0;
            stat_d  = ST_COINCIDENT;
            two_d   = 1'b0;
            state_d = S_EMIT;
          end else begin
            state_d = S_SQDX;
          end
        end
      end
      S_SQDX: state_d = S_SQDY;
      S_SQDY: begin
        s_d     = SqW'(prod_q);
        state_d = S_SQRS;
      end
      S_SQRS: begin
        s_d     = s_q + SqW'(prod_q);
        state_d = S_SQRD;
      end
      S_SQRD: begin
        outer_d = s_q > SqW'(prod_q);
        state_d = S_SQR1;
      end
      S_SQR1: begin
        inner_d    = s_q < SqW'(prod_q);
        sqrt_start = 1'b1;
        state_d    = S_DROOT;
      end
      S_DROOT: begin
        r1sq_d = (2*RadW)'(prod_q);
        if (sqrt_done) begin
          d_d = sqrt_root;
          k_d = DenW'(kfull);
          if (outer_q || inner_q) begin
            if (!ve_i) begin
              p3x_d   = '0;
              p3y_d   = '0;
              stat_d  = ST_NONE;
              two_d   = 1'b0;
              state_d = S_EMIT;
            end else begin
              state_d = S_VMX;
            end
          end else begin
            state_d = S_AR2;
          end
        end
      end
      S_VMX: state_d = S_VAX;
      S_VAX: begin
        acc_d     = sgn(prod_q, vneg ^ dxneg);
        div_start = 1'b1;
        state_d   = S_VWX;
      end
      S_VWX: begin
        if (div_done) begin
          p3x_d     = place(vbx, div_off);
          acc_d     = sgn(prod_q, vneg ^ dyneg);
          div_start = 1'b1;
          state_d   = S_VWY;
        end
      end
      S_VWY: begin
        if (div_done) begin
          p3y_d   = place(vby, div_off);
          stat_d  = outer_q ? ST_OUTER : ST_INNER;
          two_d   = 1'b0;
          state_d = S_EMIT;
        end
      end
      S_AR2: state_d = S_ANUM;
      S_ANUM: begin
        acc_d     = $signed(AccW'(r1sq_q)) - $signed(AccW'(prod_q)) + $signed(AccW'(s_q));
        div_start = 1'b1;
        state_d   = S_AWAIT;
      end
      S_AWAIT: begin
        if (div_done) begin
          a_d     = div_off;
          state_d = S_HSQ;
        end
      end
      S_HSQ: state_d = S_HSUB;
      S_HSUB: begin
        acc_d = $signed(AccW'(r1sq_q)) - $signed(AccW'(prod_q));
        if (acc_d[AccW-1]) begin
          h_d     = '0;
          state_d = S_PADX;
        end else begin
          sqrt_start = 1'b1;
          state_d    = S_HWAIT;
        end
      end
      S_HWAIT: begin
        if (sqrt_done) begin
          h_d     = (RadW+1)'(sqrt_root);
          state_d = S_PADX;
        end
      end
      S_PADX: state_d = S_PHDY;
      S_PHDY: begin
        acc_d   = sgn(prod_q, aneg ^ dxneg);
        state_d = S_PSX;
      end
      S_PSX: begin
        acc_d     = acc_q + sgn(prod_q, dyneg);
        acc2_d    = acc_q - sgn(prod_q, dyneg);
        den_d2    = 1'b0;
        div_start = 1'b1;
        state_d   = S_DX3;
      end
      S_DX3: begin
        den_d2 = 1'b0;
        if (div_done) begin
          p3x_d     = place(job_q.x1, div_off);
          acc_d     = acc2_q;
          div_start = 1'b1;
          state_d   = S_DX4;
        end
      end
      S_DX4: begin
        if (div_done) begin
          p4x_d   = place(job_q.x1, div_off);
          state_d = S_PADY;
        end
      end
      S_PADY: state_d = S_PHDX;
      S_PHDX: begin
        acc_d   = sgn(prod_q, aneg ^ dyneg);
        state_d = S_PSY;
      end
      S_PSY: begin
        acc_d     = acc_q - sgn(prod_q, dxneg);
        acc2_d    = acc_q + sgn(prod_q, dxneg);
        den_d2    = 1'b0;
        div_start = 1'b1;
        state_d   = S_DY3;
      end
      S_DY3: begin
        den_d2 = 1'b0;
        if (div_done) begin
          p3y_d     = place(job_q.y1, div_off);
          acc_d     = acc2_q;
          div_start = 1'b1;
          state_d   = S_DY4;
        end
      end
      S_DY4: begin
        if (div_done) begin
          p4y_d   = place(job_q.y1, div_off);
          stat_d  = ST_CROSS;
          two_d   = !((p3x_q == p4x_q) && (p3y_q == place(job_q.y1, div_off)));
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        rec_valid_o = 1'b1;
        if (rec_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    s_q     <= s_d;
    outer_q <= outer_d;
    inner_q <= inner_d;
    d_q     <= d_d;
    k_q     <= k_d;
    r1sq_q  <= r1sq_d;
    a_q     <= a_d;
    h_q     <= h_d;
    acc_q   <= acc_d;
    acc2_q  <= acc2_d;
    p3x_q   <= p3x_d;
    p3y_q   <= p3y_d;
    p4x_q   <= p4x_d;
    p4y_q   <= p4y_d;
    stat_q  <= stat_d;
    two_q   <= two_d;
  end

  always_comb begin
    rec_o.p3x    = p3x_q;
    rec_o.p3y    = p3y_q;
    rec_o.p4x    = p4x_q;
    rec_o.p4y    = p4y_q;
    rec_o.status = stat_q;
    rec_o.two    = two_q;
    rec_o.r1     = job_q.r1;
    rec_o.r2     = job_q.r2;
    rec_o.st1    = job_q.st1;
    rec_o.st2    = job_q.st2;
  end

  cci_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_d),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .off_o   (div_off)
  );

  cci_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_rad),
    .busy_o  (sqrt_busy),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  `CCI_ASSERT_NOW(a_div_free, div_start, !div_busy, "divider started while busy")
  `CCI_ASSERT_NOW(a_sqrt_free, sqrt_start, !sqrt_busy, "square root started while busy")
  `CCI_ASSERT_NOW(a_idle_units, state_q == S_IDLE, !div_busy && !sqrt_busy,
                  "arithmetic unit still busy in idle")
  `CCI_ASSERT_NEXT(a_pop_leaves_idle, pop_o, state_q != S_IDLE, "request popped without start")

endmodule

FILE: src/cci_out.sv
// Output stage: holds one finished record and sends its one or two results.
// Depends on cci_pkg.
module cci_out
  import cci_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rec_valid_i,
  output logic                rec_ready_o,
  input  rec_t                rec_i,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // point_x, point_y, radius1_out, radius2_out, stamp1_out, stamp2_out, two zero bits
  output logic [OutDataW-1:0] m_axis_tdata,
  // status
  output logic [StatusW-1:0]  m_axis_tuser,
  output logic                m_axis_tlast
);

  logic hold_q, second_q, beat_done;
  rec_t rec_q;

  assign m_axis_tvalid = hold_q;
  assign m_axis_tlast  = !rec_q.two || second_q;
  assign m_axis_tuser  = rec_q.status;
  assign m_axis_tdata  = {2'b00, rec_q.st2, rec_q.st1, rec_q.r2, rec_q.r1,
                          second_q ? rec_q.p4y : rec_q.p3y,
                          second_q ? rec_q.p4x : rec_q.p3x};
  assign beat_done     = hold_q && m_axis_tready && m_axis_tlast;
  assign rec_ready_o   = !hold_q || beat_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q   <= 1'b0;
      second_q <= 1'b0;
    end else begin
      if (rec_valid_i && rec_ready_o) begin
        hold_q   <= 1'b1;
        second_q <= 1'b0;
      end else if (beat_done) begin
        hold_q   <= 1'b0;
        second_q <= 1'b0;
      end else if (hold_q && m_axis_tready) begin
        second_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_valid_i && rec_ready_o) begin
      rec_q <= rec_i;
    end
  end

endmodule
